@@ design/lrs_pkg.sv @@
package lrs_pkg;

    localparam int unsigned TIME_W = 32;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned IN_DATA_W = 40;
    localparam int unsigned OUT_DATA_W = 40;

    // connection modes
    localparam logic [1:0] MODE_IDLE        = 2'd0;
    localparam logic [1:0] MODE_CONNECTING  = 2'd1;
    localparam logic [1:0] MODE_CONNECTED   = 2'd2;
    localparam logic [1:0] MODE_FAILED_WAIT = 2'd3;

    // request kinds
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_POLL  = 1'b1;

    // link status classes
    localparam logic [1:0] LINK_UP     = 2'd1;
    localparam logic [1:0] LINK_FAILED = 2'd2;

    // event codes
    localparam logic [2:0] EV_NONE      = 3'd0;
    localparam logic [2:0] EV_CONNECTED = 3'd1;
    localparam logic [2:0] EV_LINK_FAIL = 3'd2;
    localparam logic [2:0] EV_TIMEOUT   = 3'd3;
    localparam logic [2:0] EV_REFUSED   = 3'd4;
    localparam logic [2:0] EV_DROPPED   = 3'd5;
    localparam logic [2:0] EV_THROTTLED = 3'd6;

    // backoff steps
    localparam logic [1:0] STEP_FIRST  = 2'd0;
    localparam logic [1:0] STEP_SECOND = 2'd1;
    localparam logic [1:0] STEP_MAX    = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CONNECT_TIMEOUT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POLL_INTERVAL   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RETRY_FIRST     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RETRY_SECOND    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RETRY_MAX       = 3'd4;

    // half the time range: a due time is reached when now - due falls below this
    localparam logic [TIME_W-1:0] HALF_RANGE = 32'h8000_0000;

    typedef struct packed {
        logic [TIME_W-1:0] attempt_limit_ms;
        logic [TIME_W-1:0] poll_interval_ms;
        logic [TIME_W-1:0] retry_first_ms;
        logic [TIME_W-1:0] retry_second_ms;
        logic [TIME_W-1:0] retry_max_ms;
    } t_cfg;

    typedef struct packed {
        logic              req_type;
        logic [TIME_W-1:0] now_ms;
        logic [1:0]        link_state;
        logic              connect_refused;
    } t_item;

    typedef struct packed {
        logic [1:0]        conn_state;
        logic              connect_issued;
        logic [2:0]        event_code;
        logic [TIME_W-1:0] retry_wait_ms;
        logic              first_connect;
    } t_result;

    typedef struct packed {
        logic [1:0]        mode;
        logic [TIME_W-1:0] attempt_start;
        logic [TIME_W-1:0] retry_due;
        logic [1:0]        backoff_step;
        logic [TIME_W-1:0] last_poll_time;
        logic              ever_connected;
    } t_state;

endpackage

@@ design/lrs_cfg_regs.sv @@
module lrs_cfg_regs
    import lrs_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [TIME_W-1:0]    i_cfg_wdata,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.attempt_limit_ms   <= 32'd15000;
            r_cfg.poll_interval_ms   <= 32'd1000;
            r_cfg.retry_first_ms     <= 32'd5000;
            r_cfg.retry_second_ms    <= 32'd10000;
            r_cfg.retry_max_ms       <= 32'd30000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_CONNECT_TIMEOUT: r_cfg.attempt_limit_ms   <= i_cfg_wdata;
                REG_POLL_INTERVAL:   r_cfg.poll_interval_ms   <= i_cfg_wdata;
                REG_RETRY_FIRST:     r_cfg.retry_first_ms     <= i_cfg_wdata;
                REG_RETRY_SECOND:    r_cfg.retry_second_ms    <= i_cfg_wdata;
                REG_RETRY_MAX:       r_cfg.retry_max_ms       <= i_cfg_wdata;
                default: begin
                    // drop writes to unused indexes
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ design/lrs_step_logic.sv @@
module lrs_step_logic
    import lrs_pkg::*;
(
    input  t_item   i_item,
    input  t_state  i_state,
    input  t_cfg    i_cfg,
    output t_state  o_state,
    output t_result o_result
);

    logic [TIME_W-1:0] delay;
    logic [1:0]        fail_step;
    logic [TIME_W-1:0] since_poll;
    logic [TIME_W-1:0] since_start;
    logic [TIME_W-1:0] past_due;
    logic              throttled;
    logic              timed_out;
    logic              due;

    always_comb begin
        case (i_state.backoff_step)
            STEP_FIRST:  delay = i_cfg.retry_first_ms;
            STEP_SECOND: delay = i_cfg.retry_second_ms;
            default:     delay = i_cfg.retry_max_ms;
        endcase
        fail_step = (i_state.backoff_step < STEP_MAX) ? i_state.backoff_step + 2'd1 : STEP_MAX;
    end

    assign since_poll  = i_item.now_ms - i_state.last_poll_time;
    assign since_start = i_item.now_ms - i_state.attempt_start;
    assign past_due    = i_item.now_ms - i_state.retry_due;
    assign throttled   = since_poll < i_cfg.poll_interval_ms;
    assign timed_out   = since_start >= i_cfg.attempt_limit_ms;
    assign due         = past_due < HALF_RANGE;

    always_comb begin
        logic go_fail;
        logic go_connect;
        go_fail    = 1'b0;
        go_connect = 1'b0;
        o_state    = i_state;
        o_result   = '0;

        if (i_item.req_type == REQ_START) begin
            go_connect = 1'b1;
        end else if (i_state.mode != MODE_IDLE) begin
            if (throttled) begin
                o_result.event_code = EV_THROTTLED;
            end else begin
                o_state.last_poll_time = i_item.now_ms;
                unique case (i_state.mode)
                    MODE_CONNECTING: begin
                        if (i_item.link_state == LINK_UP) begin
                            o_state.mode           = MODE_CONNECTED;
                            o_state.backoff_step   = STEP_FIRST;
                            o_state.ever_connected = 1'b1;
                            o_result.event_code    = EV_CONNECTED;
                            o_result.first_connect = ~i_state.ever_connected;
                        end else if (i_item.link_state == LINK_FAILED) begin
                            go_fail             = 1'b1;
                            o_result.event_code = EV_LINK_FAIL;
                        end else if (timed_out) begin
                            go_fail             = 1'b1;
                            o_result.event_code = EV_TIMEOUT;
                        end
                    end
                    MODE_FAILED_WAIT: begin
                        go_connect = due;
                    end
                    MODE_CONNECTED: begin
                        if (i_item.link_state != LINK_UP) begin
                            go_fail             = 1'b1;
                            o_result.event_code = EV_DROPPED;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end

        if (go_connect) begin
            o_result.connect_issued = 1'b1;
            if (i_item.connect_refused) begin
                go_fail             = 1'b1;
                o_result.event_code = EV_REFUSED;
            end else begin
                o_state.attempt_start = i_item.now_ms;
                o_state.mode          = MODE_CONNECTING;
            end
        end

        if (go_fail) begin
            o_state.mode           = MODE_FAILED_WAIT;
            o_state.backoff_step   = fail_step;
            o_state.retry_due      = i_item.now_ms + delay;
            o_result.retry_wait_ms = delay;
        end

        o_result.conn_state = o_state.mode;
    end

endmodule

@@ design/link_retry_supervisor_unit.sv @@
// Link retry supervisor. Each input item is a start request (tuser = 0) or a
// poll (tuser = 1) carrying the millisecond time, the link status class and a
// refused flag for a connect attempt issued by that item; each item yields
// exactly one result item with the new connection state, whether a connect
// was issued, an event code, the retry delay applied on entering failed wait
// and a first-connection flag. Items flow through an input register, the
// decision logic that also updates the supervisor state, and an output
// register, so the block takes one item per cycle while the output side
// keeps up; a result item is offered once its item has passed the input
// and output registers, and is taken when the output side is ready; the
// output register lets a new item enter while a result waits.
// Configuration registers are written through the plain write port and
// should change only while no item is in flight.
module link_retry_supervisor_unit
    import lrs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [TIME_W-1:0]     i_cfg_wdata,
    // request items
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // [31:0] now_ms, [33:32] link_state, [34] connect_refused, [39:35] zero
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // [0] req_type
    input  logic                  i_s_axis_tuser,
    // result items
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // [1:0] conn_state, [2] connect_issued, [5:3] event_code,
    // [37:6] retry_wait_ms, [38] first_connect, [39] zero
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata
);

    t_cfg    cfg;
    t_state  r_state;
    t_state  n_state;
    t_result step_result;

    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;
    logic    advance;

    lrs_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    lrs_step_logic u_step (
        .i_item   (r_in),
        .i_state  (r_state),
        .i_cfg    (cfg),
        .o_state  (n_state),
        .o_result (step_result)
    );

    // Move the held item into the output register when that slot is free or
    // being emptied this cycle; the state commits at the same edge.
    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in.req_type        <= i_s_axis_tuser;
            r_in.now_ms          <= i_s_axis_tdata[31:0];
            r_in.link_state      <= i_s_axis_tdata[33:32];
            r_in.connect_refused <= i_s_axis_tdata[34];
        end
    end

    // Supervisor state: advance once per item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode           <= MODE_IDLE;
            r_state.attempt_start  <= '0;
            r_state.retry_due      <= '0;
            r_state.backoff_step   <= STEP_FIRST;
            r_state.last_poll_time <= '0;
            r_state.ever_connected <= 1'b0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= step_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_out.first_connect, r_out.retry_wait_ms,
                              r_out.event_code, r_out.connect_issued, r_out.conn_state};

`ifndef ASSERT_OFF
    // A nonzero retry delay is only reported on entry to failed wait.
    a_wait_only_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (r_out.retry_wait_ms != '0) |-> r_out.conn_state == MODE_FAILED_WAIT)
        else $error("retry delay reported outside failed wait");

    // First connection flag comes with the connected event and state.
    a_first_is_connect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && r_out.first_connect |->
            (r_out.event_code == EV_CONNECTED) && (r_out.conn_state == MODE_CONNECTED))
        else $error("first_connect without a connection");

    // A refusal can only follow an issued connect attempt.
    a_refused_issued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (r_out.event_code == EV_REFUSED) |-> r_out.connect_issued)
        else $error("refused event without a connect attempt");

    // The backoff saturates at the maximum step.
    a_backoff_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.backoff_step != 2'd3)
        else $error("backoff step out of range");

    // The supervisor state only changes when an item is processed.
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_state))
        else $error("state changed without an item");
`endif

endmodule
